/* rtl/rsdc_pkg.sv */
package rsdc_pkg;

  // Input function codes.
  localparam logic [2:0] FUNC_SCAN_TICK = 3'd0;
  localparam logic [2:0] FUNC_SIGNAL    = 3'd1;
  localparam logic [2:0] FUNC_ENCODER   = 3'd2;
  localparam logic [2:0] FUNC_PAUSE     = 3'd3;
  localparam logic [2:0] FUNC_DIRECTION = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] CFG_RANGE_START = 3'd0;
  localparam logic [2:0] CFG_STEP        = 3'd1;
  localparam logic [2:0] CFG_CHAN_COUNT  = 3'd2;
  localparam logic [2:0] CFG_SQUELCH     = 3'd3;
  localparam logic [2:0] CFG_BROWSE_WAIT = 3'd4;
  localparam logic [2:0] CFG_LOCK_WAIT   = 3'd5;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 34;

  // Pending one-shot step codes.
  localparam logic [1:0] STEP_NONE = 2'd0;
  localparam logic [1:0] STEP_FWD  = 2'd1;
  localparam logic [1:0] STEP_BACK = 2'd2;

  localparam logic [15:0] TIMER_MAX = 16'hFFFF;

  typedef struct packed {
    logic [33:0]        range_start_hz;
    logic [26:0]        step_hz;
    logic [15:0]        channel_count;
    logic signed [7:0]  squelch_db;
    logic [7:0]         browse_wait_s;
    logic [7:0]         lock_wait_s;
  } cfg_t;

  typedef struct packed {
    logic [33:0] frequency_hz;
    logic [15:0] channel_number;
    logic        retuned;
    logic        report_valid;
    logic        audio_enabled;
    logic        display_color;
    logic [7:0]  lock_level;
    logic        scan_active;
    logic        held_by_user;
  } result_t;

endpackage

/* rtl/rsdc_regs.sv */
module rsdc_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [rsdc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rsdc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output rsdc_pkg::cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.range_start_hz <= 34'd0;
      cfg.step_hz        <= 27'd25000;
      cfg.channel_count  <= 16'd1;
      cfg.squelch_db     <= -8'sd80;
      cfg.browse_wait_s  <= 8'd0;
      cfg.lock_wait_s    <= 8'd1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rsdc_pkg::CFG_RANGE_START: cfg.range_start_hz <= cfg_data[33:0];
        rsdc_pkg::CFG_STEP:        cfg.step_hz        <= cfg_data[26:0];
        rsdc_pkg::CFG_CHAN_COUNT:  cfg.channel_count  <= cfg_data[15:0];
        rsdc_pkg::CFG_SQUELCH:     cfg.squelch_db     <= $signed(cfg_data[7:0]);
        rsdc_pkg::CFG_BROWSE_WAIT: cfg.browse_wait_s  <= cfg_data[7:0];
        rsdc_pkg::CFG_LOCK_WAIT:   cfg.lock_wait_s    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/rsdc_core.sv */
module rsdc_core #(
  parameter int LOCK_CHECKS     = 10,
  parameter int REPORTS_PER_SEC = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  logic [2:0]         func,
  input  logic signed [7:0]  signal_level,
  input  logic               turn_dir,
  input  rsdc_pkg::cfg_t     cfg,
  output rsdc_pkg::result_t  result
);

  logic [15:0] chan_idx, chan_idx_next;
  logic        first_pass, first_pass_next;
  logic [7:0]  lock_count, lock_count_next;
  logic        scanning_on, scanning_on_next;
  logic        user_hold, user_hold_next;
  logic [1:0]  pending_step, pending_step_next;
  logic        forward_dir, forward_dir_next;
  logic [15:0] browse_count, browse_count_next;
  logic [15:0] lost_count, lost_count_next;
  logic [1:0]  color_count, color_count_next;
  logic        audio_on, audio_on_next;
  logic        color_now, color_now_next;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == rsdc_pkg::TIMER_MAX) ? v : v + 16'd1;
  endfunction

  always_comb begin
    logic [15:0] cur;
    logic [15:0] idx;
    logic [15:0] browse_limit;
    logic [15:0] lost_limit;
    logic [15:0] lost_inc;
    logic [16:0] cur_plus;
    logic [1:0]  cc_inc;
    logic [42:0] product;
    logic        above;
    logic        force_step;
    logic        step_fwd;
    logic        do_colour;
    logic        retuned;
    logic        reported;

    chan_idx_next     = chan_idx;
    first_pass_next   = first_pass;
    lock_count_next   = lock_count;
    scanning_on_next  = scanning_on;
    user_hold_next    = user_hold;
    pending_step_next = pending_step;
    forward_dir_next  = forward_dir;
    browse_count_next = browse_count;
    lost_count_next   = lost_count;
    color_count_next  = color_count;
    audio_on_next     = audio_on;
    color_now_next    = color_now;
    retuned   = 1'b0;
    reported  = 1'b0;
    do_colour = 1'b0;

    cur          = first_pass ? cfg.channel_count : chan_idx;
    cur_plus     = {1'b0, cur} + 17'd1;
    browse_limit = 16'(cfg.browse_wait_s) * 16'(REPORTS_PER_SEC);
    lost_limit   = 16'(cfg.lock_wait_s) * 16'(REPORTS_PER_SEC);
    lost_inc     = sat_inc(lost_count);
    cc_inc       = color_count + 2'd1;
    above        = signal_level > cfg.squelch_db;
    force_step   = pending_step != rsdc_pkg::STEP_NONE;
    step_fwd     = force_step ? (pending_step == rsdc_pkg::STEP_FWD) : forward_dir;

    unique case (func)
      rsdc_pkg::FUNC_SCAN_TICK: begin
        if (scanning_on || force_step) begin
          if (lock_count == 8'd0 || force_step) begin
            if (step_fwd) begin
              chan_idx_next = (cur_plus >= {1'b0, cfg.channel_count}) ? 16'd0 : cur_plus[15:0];
            end else if (cur == 16'd0) begin
              chan_idx_next = cfg.channel_count - 16'd1;
            end else begin
              chan_idx_next = (cur - 16'd1 >= cfg.channel_count) ? 16'd0 : cur - 16'd1;
            end
            first_pass_next   = 1'b0;
            pending_step_next = rsdc_pkg::STEP_NONE;
            retuned           = 1'b1;
          end
          reported = 1'b1;
        end
      end
      rsdc_pkg::FUNC_SIGNAL: begin
        if (user_hold) begin
          do_colour = 1'b1;
        end else if (cfg.browse_wait_s != 8'd0 && browse_count >= browse_limit) begin
          browse_count_next = 16'd0;
          audio_on_next     = 1'b0;
          color_now_next    = 1'b0;
          pending_step_next = forward_dir ? rsdc_pkg::STEP_FWD : rsdc_pkg::STEP_BACK;
          scanning_on_next  = 1'b1;
        end else if (above) begin
          if (lock_count >= 8'(LOCK_CHECKS)) begin
            if (browse_count == 16'd0) begin
              if (scanning_on) begin
                lock_count_next  = 8'd0;
                scanning_on_next = 1'b0;
              end
              audio_on_next = 1'b1;
            end
            browse_count_next = sat_inc(browse_count);
            do_colour = 1'b1;
          end else begin
            lock_count_next = lock_count + 8'd1;
            if (browse_count != 16'd0) begin
              browse_count_next = sat_inc(browse_count);
            end
          end
          lost_count_next = 16'd0;
        end else if (browse_count == 16'd0) begin
          if (lock_count != 8'd0) begin
            color_now_next  = 1'b0;
            lock_count_next = 8'd0;
          end
        end else begin
          lost_count_next = lost_inc;
          if (lost_inc >= lost_limit) begin
            browse_count_next = 16'd0;
            audio_on_next     = 1'b0;
            color_now_next    = 1'b0;
            pending_step_next = forward_dir ? rsdc_pkg::STEP_FWD : rsdc_pkg::STEP_BACK;
            scanning_on_next  = 1'b1;
          end else begin
            browse_count_next = sat_inc(browse_count);
            do_colour = 1'b1;
          end
        end
        // The color timer always acts last, after any pause above.
        if (do_colour) begin
          if (cc_inc == 2'd3) begin
            audio_on_next    = above;
            color_now_next   = above;
            color_count_next = 2'd0;
          end else begin
            color_count_next = cc_inc;
          end
        end
      end
      rsdc_pkg::FUNC_ENCODER: begin
        pending_step_next = turn_dir ? rsdc_pkg::STEP_FWD : rsdc_pkg::STEP_BACK;
        if (browse_count != 16'd0) begin
          browse_count_next = 16'd1;
        end
      end
      rsdc_pkg::FUNC_PAUSE: begin
        if (user_hold) begin
          browse_count_next = browse_limit + 16'd1;
          user_hold_next    = 1'b0;
        end else begin
          if (scanning_on) begin
            lock_count_next  = 8'd0;
            scanning_on_next = 1'b0;
          end
          audio_on_next  = 1'b1;
          user_hold_next = 1'b1;
        end
      end
      rsdc_pkg::FUNC_DIRECTION: begin
        forward_dir_next = !forward_dir;
        if (user_hold) begin
          browse_count_next = browse_limit + 16'd1;
          user_hold_next    = 1'b0;
        end
        color_now_next = 1'b0;
      end
      default: ;
    endcase

    idx     = first_pass_next ? cfg.channel_count : chan_idx_next;
    product = 43'(idx) * 43'(cfg.step_hz);

    result.frequency_hz   = cfg.range_start_hz + product[33:0];
    result.channel_number = idx;
    result.retuned        = retuned;
    result.report_valid   = reported;
    result.audio_enabled  = audio_on_next;
    result.display_color  = color_now_next;
    result.lock_level     = lock_count_next;
    result.scan_active    = scanning_on_next;
    result.held_by_user   = user_hold_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chan_idx     <= 16'd0;
      first_pass   <= 1'b1;
      lock_count   <= 8'd0;
      scanning_on  <= 1'b1;
      user_hold    <= 1'b0;
      pending_step <= rsdc_pkg::STEP_NONE;
      forward_dir  <= 1'b1;
      browse_count <= 16'd0;
      lost_count   <= 16'd0;
      color_count  <= 2'd0;
      audio_on     <= 1'b0;
      color_now    <= 1'b0;
    end else if (fire) begin
      chan_idx     <= chan_idx_next;
      first_pass   <= first_pass_next;
      lock_count   <= lock_count_next;
      scanning_on  <= scanning_on_next;
      user_hold    <= user_hold_next;
      pending_step <= pending_step_next;
      forward_dir  <= forward_dir_next;
      browse_count <= browse_count_next;
      lost_count   <= lost_count_next;
      color_count  <= color_count_next;
      audio_on     <= audio_on_next;
      color_now    <= color_now_next;
    end
  end

  // The lock counter only counts up while below the threshold.
  a_lock_bound: assert property (@(posedge clk) disable iff (rst)
    lock_count <= 8'(LOCK_CHECKS))
    else $error("lock counter above threshold");

  a_hold_paused: assert property (@(posedge clk) disable iff (rst)
    user_hold |-> !scanning_on)
    else $error("scan running while held by user");

  a_pending_code: assert property (@(posedge clk) disable iff (rst)
    pending_step != 2'd3)
    else $error("invalid pending step code");

  a_colour_wrap: assert property (@(posedge clk) disable iff (rst)
    color_count != 2'd3)
    else $error("color timer not wrapped");

endmodule

/* rtl/rsdc_obuf.sv */
module rsdc_obuf (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  rsdc_pkg::result_t  push_data,
  output logic               push_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output rsdc_pkg::result_t  out_data
);

  logic               main_valid;
  logic               skid_valid;
  rsdc_pkg::result_t  main_data;
  rsdc_pkg::result_t  skid_data;
  logic               pop;

  assign pop        = main_valid && out_ready;
  assign push_ready = !skid_valid;
  assign out_valid  = main_valid;
  assign out_data   = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid || pop) begin
        main_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        main_data <= skid_data;
      end
    end else if (push) begin
      if (!main_valid || pop) begin
        main_data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end
  end

  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid word held without a main word");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    !(push && skid_valid))
    else $error("word pushed into a full buffer");

endmodule

/* rtl/radio_scan_dwell_controller.sv */
// A result word is formed combinationally from its accepted input word and registered in the output buffer.
// Throughput: one word per cycle while the output buffer has room; the state update and the 16x27 frequency
// multiply-add are done combinationally between acceptance and the output register.
// A two-entry output buffer keeps taking words while one result waits for the consumer.
// Reset: synchronous rst loads the register defaults and the initial scanning state, empties the buffer.
module radio_scan_dwell_controller #(
  parameter int LOCK_CHECKS     = 10,
  parameter int REPORTS_PER_SEC = 10
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [rsdc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rsdc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [2:0]                       func,
  input  logic signed [7:0]                signal_level,
  input  logic                             turn_dir,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [33:0]                      frequency_hz,
  output logic [15:0]                      channel_number,
  output logic                             retuned,
  output logic                             report_valid,
  output logic                             audio_enabled,
  output logic                             display_color,
  output logic [7:0]                       lock_level,
  output logic                             scan_active,
  output logic                             held_by_user
);

  rsdc_pkg::cfg_t     cfg;
  rsdc_pkg::result_t  result;
  rsdc_pkg::result_t  out_data;
  logic               fire;

  assign fire = in_valid && in_ready;

  rsdc_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rsdc_core #(
    .LOCK_CHECKS     (LOCK_CHECKS),
    .REPORTS_PER_SEC (REPORTS_PER_SEC)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .func         (func),
    .signal_level (signal_level),
    .turn_dir     (turn_dir),
    .cfg          (cfg),
    .result       (result)
  );

  rsdc_obuf u_obuf (
    .clk        (clk),
    .rst        (rst),
    .push       (fire),
    .push_data  (result),
    .push_ready (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  assign frequency_hz   = out_data.frequency_hz;
  assign channel_number = out_data.channel_number;
  assign retuned        = out_data.retuned;
  assign report_valid   = out_data.report_valid;
  assign audio_enabled  = out_data.audio_enabled;
  assign display_color  = out_data.display_color;
  assign lock_level     = out_data.lock_level;
  assign scan_active    = out_data.scan_active;
  assign held_by_user   = out_data.held_by_user;

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps

module testbench;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_WORDS = 115;

  // Tracks the controller state and holds the status words still owed by the block.
  class scan_scoreboard;
    localparam int LOCK_CHECKS     = 10;
    localparam int REPORTS_PER_SEC = 10;

    rsdc_pkg::cfg_t    regs;
    bit [15:0]         chan_idx;
    bit                first_pass;
    bit [7:0]          lock_count;
    bit                scanning_on;
    bit                user_hold;
    bit [1:0]          pending_step;
    bit                forward_dir;
    int unsigned       browse_count;
    int unsigned       lost_count;
    bit [1:0]          color_count;
    bit                audio_on;
    bit                color_now;
    rsdc_pkg::result_t expected_status[$];
    int                errors;

    function new();
      regs.range_start_hz = '0;
      regs.step_hz        = 27'd25000;
      regs.channel_count  = 16'd1;
      regs.squelch_db     = -8'sd80;
      regs.browse_wait_s  = 8'd0;
      regs.lock_wait_s    = 8'd1;
      chan_idx     = '0;
      first_pass   = 1'b1;
      lock_count   = '0;
      scanning_on  = 1'b1;
      user_hold    = 1'b0;
      pending_step = rsdc_pkg::STEP_NONE;
      forward_dir  = 1'b1;
      browse_count = 0;
      lost_count   = 0;
      color_count  = '0;
      audio_on     = 1'b0;
      color_now    = 1'b0;
      errors       = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [33:0] d);
      case (idx)
        rsdc_pkg::CFG_RANGE_START: regs.range_start_hz = d;
        rsdc_pkg::CFG_STEP:        regs.step_hz        = d[26:0];
        rsdc_pkg::CFG_CHAN_COUNT:  regs.channel_count  = d[15:0];
        rsdc_pkg::CFG_SQUELCH:     regs.squelch_db     = d[7:0];
        rsdc_pkg::CFG_BROWSE_WAIT: regs.browse_wait_s  = d[7:0];
        rsdc_pkg::CFG_LOCK_WAIT:   regs.lock_wait_s    = d[7:0];
        default: ;
      endcase
    endfunction

    function int unsigned bump(int unsigned v);
      return (v >= rsdc_pkg::TIMER_MAX) ? rsdc_pkg::TIMER_MAX : v + 1;
    endfunction

    function bit above_squelch(int level);
      return level > int'($signed(regs.squelch_db));
    endfunction

    function void update_color(int level);
      color_count = color_count + 2'd1;
      if (color_count > 2) begin
        audio_on    = above_squelch(level);
        color_now   = above_squelch(level);
        color_count = '0;
      end
    endfunction

    function void pause_scan();
      if (scanning_on) begin
        lock_count  = '0;
        scanning_on = 1'b0;
      end
      audio_on = 1'b1;
    endfunction

    function void resume_scan();
      audio_on     = 1'b0;
      color_now    = 1'b0;
      pending_step = forward_dir ? rsdc_pkg::STEP_FWD : rsdc_pkg::STEP_BACK;
      scanning_on  = 1'b1;
    endfunction

    function void release_hold();
      browse_count = int'(regs.browse_wait_s) * REPORTS_PER_SEC + 1;
      user_hold    = 1'b0;
    endfunction

    function void take_signal(int level);
      int unsigned browse_limit;
      int unsigned lost_limit;
      browse_limit = int'(regs.browse_wait_s) * REPORTS_PER_SEC;
      lost_limit   = int'(regs.lock_wait_s) * REPORTS_PER_SEC;
      if (user_hold) begin
        update_color(level);
        return;
      end
      if (regs.browse_wait_s != 0 && browse_count >= browse_limit) begin
        browse_count = 0;
        resume_scan();
      end else if (above_squelch(level)) begin
        if (lock_count >= LOCK_CHECKS) begin
          if (browse_count == 0) pause_scan();
          browse_count = bump(browse_count);
          update_color(level);
        end else begin
          lock_count = lock_count + 8'd1;
          if (browse_count != 0) browse_count = bump(browse_count);
        end
        lost_count = 0;
      end else if (browse_count == 0) begin
        if (lock_count > 0) begin
          color_now  = 1'b0;
          lock_count = '0;
        end
      end else begin
        lost_count = bump(lost_count);
        if (lost_count >= lost_limit) begin
          browse_count = 0;
          resume_scan();
        end else begin
          browse_count = bump(browse_count);
          update_color(level);
        end
      end
    endfunction

    // Advances the state by one accepted input word and queues the status it must produce.
    function void note_word(logic [2:0] f, logic signed [7:0] level8, logic td);
      bit                force_step;
      bit                step_fwd;
      bit                tuned;
      bit                reported;
      int                nxt;
      int                level;
      bit [15:0]         idx;
      logic [63:0]       sum;
      rsdc_pkg::result_t r;
      tuned    = 1'b0;
      reported = 1'b0;
      level    = level8;
      case (f)
        rsdc_pkg::FUNC_SCAN_TICK: begin
          force_step = pending_step != rsdc_pkg::STEP_NONE;
          step_fwd   = force_step ? (pending_step == rsdc_pkg::STEP_FWD) : forward_dir;
          if (scanning_on || force_step) begin
            if (lock_count == 0 || force_step) begin
              idx = first_pass ? regs.channel_count : chan_idx;
              nxt = int'(idx) + (step_fwd ? 1 : -1);
              if (nxt >= int'(regs.channel_count)) nxt = 0;
              else if (nxt < 0) nxt = int'(regs.channel_count) - 1;
              chan_idx     = 16'(nxt);
              first_pass   = 1'b0;
              pending_step = rsdc_pkg::STEP_NONE;
              tuned        = 1'b1;
            end
            reported = 1'b1;
          end
        end
        rsdc_pkg::FUNC_SIGNAL: take_signal(level);
        rsdc_pkg::FUNC_ENCODER: begin
          pending_step = td ? rsdc_pkg::STEP_FWD : rsdc_pkg::STEP_BACK;
          if (browse_count != 0) browse_count = 1;
        end
        rsdc_pkg::FUNC_PAUSE: begin
          if (user_hold) begin
            release_hold();
          end else begin
            pause_scan();
            user_hold = 1'b1;
          end
        end
        rsdc_pkg::FUNC_DIRECTION: begin
          forward_dir = !forward_dir;
          if (user_hold) release_hold();
          color_now = 1'b0;
        end
        default: ;
      endcase
      idx = first_pass ? regs.channel_count : chan_idx;
      sum = 64'(regs.range_start_hz) + 64'(idx) * 64'(regs.step_hz);
      r.frequency_hz   = sum[33:0];
      r.channel_number = idx;
      r.retuned        = tuned;
      r.report_valid   = reported;
      r.audio_enabled  = audio_on;
      r.display_color  = color_now;
      r.lock_level     = lock_count;
      r.scan_active    = scanning_on;
      r.held_by_user   = user_hold;
      expected_status.insert(expected_status.size(), r);
    endfunction

    function string show(rsdc_pkg::result_t r);
      return $sformatf({"freq=%0d ch=%0d tuned=%0b rep=%0b audio=%0b color=%0b",
                        " lock=%0d scan=%0b hold=%0b"},
                       r.frequency_hz, r.channel_number, r.retuned, r.report_valid,
                       r.audio_enabled, r.display_color, r.lock_level, r.scan_active,
                       r.held_by_user);
    endfunction

    function void check_word(rsdc_pkg::result_t got);
      rsdc_pkg::result_t want;
      if (expected_status.size() == 0) begin
        if (errors < 10) $display("status word with none expected: %s", show(got));
        errors++;
        return;
      end
      want = expected_status.pop_front();
      if (got.frequency_hz !== want.frequency_hz || got.channel_number !== want.channel_number ||
          got.retuned !== want.retuned || got.report_valid !== want.report_valid ||
          got.audio_enabled !== want.audio_enabled || got.display_color !== want.display_color ||
          got.lock_level !== want.lock_level || got.scan_active !== want.scan_active ||
          got.held_by_user !== want.held_by_user) begin
        if (errors < 10) begin
          $display("status mismatch at %0t", $realtime);
          $display("  expected %s", show(want));
          $display("  got      %s", show(got));
        end
        errors++;
      end
    endfunction

    function void account_leftovers();
      errors += expected_status.size();
      expected_status.delete();
    endfunction
  endclass

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_write = 1'b0;
  logic [rsdc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [rsdc_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic [2:0]                       func = '0;
  logic signed [7:0]                signal_level = '0;
  logic                             turn_dir = 1'b0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic [33:0]                      frequency_hz;
  logic [15:0]                      channel_number;
  logic                             retuned;
  logic                             report_valid;
  logic                             audio_enabled;
  logic                             display_color;
  logic [7:0]                       lock_level;
  logic                             scan_active;
  logic                             held_by_user;

  scan_scoreboard sb = new();
  int in_gap_pct    = 15;
  int out_stall_pct = 52;
  int cycles        = 0;

  radio_scan_dwell_controller u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .func           (func),
    .signal_level   (signal_level),
    .turn_dir       (turn_dir),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .frequency_hz   (frequency_hz),
    .channel_number (channel_number),
    .retuned        (retuned),
    .report_valid   (report_valid),
    .audio_enabled  (audio_enabled),
    .display_color  (display_color),
    .lock_level     (lock_level),
    .scan_active    (scan_active),
    .held_by_user   (held_by_user)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_word(func, signal_level, turn_dir);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_word(rsdc_pkg::result_t'({frequency_hz, channel_number, retuned,
                                         report_valid, audio_enabled, display_color,
                                         lock_level, scan_active, held_by_user}));
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  // Called just after the clock rises; returns once the word is accepted, with valid
  // still high, so a following word can take over without a dip.
  task automatic send_word(logic [2:0] f, logic signed [7:0] level, logic td);
    while ($urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    func         <= f;
    signal_level <= level;
    turn_dir     <= td;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [33:0] d);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    sb.set_reg(idx, d);
  endtask

  task automatic write_config(rsdc_pkg::cfg_t c);
    write_reg(rsdc_pkg::CFG_RANGE_START, c.range_start_hz);
    write_reg(rsdc_pkg::CFG_STEP, 34'(c.step_hz));
    write_reg(rsdc_pkg::CFG_CHAN_COUNT, 34'(c.channel_count));
    write_reg(rsdc_pkg::CFG_SQUELCH, {26'd0, c.squelch_db});
    write_reg(rsdc_pkg::CFG_BROWSE_WAIT, 34'(c.browse_wait_s));
    write_reg(rsdc_pkg::CFG_LOCK_WAIT, 34'(c.lock_wait_s));
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_status.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic signed [7:0] strong_level();
    int sq;
    sq = $signed(sb.regs.squelch_db);
    if ($urandom_range(9) == 0 || sq >= 127) return 8'($urandom);
    return 8'(sq + 1 + int'($urandom_range(0, 126 - sq)));
  endfunction

  function automatic logic signed [7:0] weak_level();
    int sq;
    sq = $signed(sb.regs.squelch_db);
    if ($urandom_range(9) == 0) return 8'($urandom);
    return 8'(-128 + int'($urandom_range(0, sq + 128)));
  endfunction

  function automatic rsdc_pkg::cfg_t phase_setting(int p);
    rsdc_pkg::cfg_t c;
    c.range_start_hz = 34'({$urandom, $urandom});
    c.step_hz        = 27'($urandom);
    c.channel_count  = 16'd6;
    c.squelch_db     = 8'($urandom);
    c.browse_wait_s  = 8'd1;
    c.lock_wait_s    = 8'd1;
    case (p)
      0: begin
        c.range_start_hz = 34'd144000000;
        c.step_hz        = 27'd25000;
        c.squelch_db     = -8'sd80;
      end
      1: begin
        c.range_start_hz = '1;
        c.step_hz        = '1;
        c.channel_count  = 16'hFFFF;
        c.squelch_db     = -8'sd128;
        c.browse_wait_s  = 8'd0;
        c.lock_wait_s    = 8'd0;
      end
      2: begin
        c.range_start_hz = '0;
        c.step_hz        = '0;
        c.channel_count  = '0;
        c.squelch_db     = 8'sd127;
        c.browse_wait_s  = 8'd255;
        c.lock_wait_s    = 8'd255;
      end
      3: begin
        c.channel_count = 16'd3;
        c.squelch_db    = 8'(int'($urandom_range(0, 80)) - 40);
        c.browse_wait_s = 8'd2;
      end
      4: begin
        c.range_start_hz = 34'd88000000;
        c.step_hz        = 27'd100000;
        c.channel_count  = 16'd1;
        c.squelch_db     = 8'sd0;
        c.lock_wait_s    = 8'd2;
      end
      default: begin
        c.channel_count = 16'($urandom_range(2, 20));
        c.browse_wait_s = 8'($urandom_range(0, 3));
        c.lock_wait_s   = 8'($urandom_range(0, 3));
      end
    endcase
    return c;
  endfunction

  task automatic run_directed();
    send_word(rsdc_pkg::FUNC_SIGNAL, -8'sd128, 1'b0);  // status shows the channel before the first step
    send_word(rsdc_pkg::FUNC_DIRECTION, 8'sd5, 1'b1);
    // The first backward step lands on the last channel.
    send_word(rsdc_pkg::FUNC_SCAN_TICK, 8'sd127, 1'b0);
    send_word(rsdc_pkg::FUNC_DIRECTION, -8'sd1, 1'b0);
    send_word(rsdc_pkg::FUNC_ENCODER, 8'sd0, 1'b0);
    send_word(rsdc_pkg::FUNC_SCAN_TICK, 8'sd0, 1'b1);
    repeat (11) send_word(rsdc_pkg::FUNC_SIGNAL, 8'sd127, 1'($urandom));
    send_word(rsdc_pkg::FUNC_SCAN_TICK, -8'sd128, 1'b1);
    send_word(rsdc_pkg::FUNC_ENCODER, 8'sd0, 1'b1);
    send_word(rsdc_pkg::FUNC_SCAN_TICK, 8'sd0, 1'b0);  // the pending step overrides the pause
    send_word(rsdc_pkg::FUNC_PAUSE, 8'sd0, 1'b0);
    send_word(rsdc_pkg::FUNC_SIGNAL, 8'sd0, 1'b0);
    send_word(rsdc_pkg::FUNC_PAUSE, 8'sd0, 1'b1);
    send_word(3'd5, 8'sd0, 1'b0);
    send_word(3'd6, 8'sd0, 1'b0);
    send_word(3'd7, -8'sd1, 1'b1);
  endtask

  task automatic run_random(int n);
    int left;
    int pick;
    int len;
    left = n;
    while (left > 0) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        len = $urandom_range(4, 16);
        repeat (len) send_word(rsdc_pkg::FUNC_SIGNAL, strong_level(), 1'($urandom));
        left -= len;
      end else if (pick < 55) begin
        len = $urandom_range(1, 12);
        repeat (len) send_word(rsdc_pkg::FUNC_SIGNAL, weak_level(), 1'($urandom));
        left -= len;
      end else if (pick < 80) begin
        len = $urandom_range(1, 4);
        repeat (len) send_word(rsdc_pkg::FUNC_SCAN_TICK, 8'($urandom), 1'($urandom));
        left -= len;
      end else if (pick < 88) begin
        send_word(rsdc_pkg::FUNC_ENCODER, 8'($urandom), 1'($urandom));
        left--;
      end else if (pick < 92) begin
        send_word(rsdc_pkg::FUNC_PAUSE, 8'($urandom), 1'($urandom));
        left--;
      end else if (pick < 96) begin
        send_word(rsdc_pkg::FUNC_DIRECTION, 8'($urandom), 1'($urandom));
        left--;
      end else if (pick < 98) begin
        send_word(3'($urandom_range(5, 7)), 8'($urandom), 1'($urandom));
      end else begin
        send_word(3'($urandom_range(0, 4)), 8'($urandom), 1'($urandom));
        left--;
      end
    end
  endtask

  initial begin
    rsdc_pkg::cfg_t c;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    c = phase_setting(0);
    c.range_start_hz = 34'd1000000;
    c.step_hz        = 27'd12500;
    c.channel_count  = 16'd5;
    write_config(c);
    run_directed();
    drain();
    for (int p = 0; p < 6; p++) begin
      case (p / 2)
        0: begin
          in_gap_pct    = 15;
          out_stall_pct = 52;
        end
        1: begin
          in_gap_pct    = 52;
          out_stall_pct = 15;
        end
        default: begin
          in_gap_pct    = 0;
          out_stall_pct = 0;
        end
      endcase
      write_config(phase_setting(p));
      run_random(PHASE_WORDS);
      drain();
    end
    repeat (10) @(posedge clk);
    sb.account_leftovers();
    if (sb.errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
